### src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Holds the operation and status codes, the per-cell command and the
// compare flags that each cell reports to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // Width of the data word carried by each entry
  localparam int DATA_W = 32;

  // Operation codes on the mode field
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_INSERTED = 2'd0;
  localparam status_t ST_DELETED  = 2'd1;
  localparam status_t ST_MISSING  = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  // Command broadcast to every cell in the cycle an item is applied
  typedef struct packed {
    logic ins;   // insert goes ahead (queue not full)
    logic del;   // delete goes ahead (key found)
  } cmd_t;

  // Compare flags that each cell reports against the broadcast key
  typedef struct packed {
    logic le;    // occupied and priority <= key
    logic lt;    // occupied and priority <  key
    logic eq;    // occupied and priority == key
    logic hit;   // first occupied cell whose priority equals the key
  } flags_t;

endpackage

`default_nettype wire

### src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry, compares its priority with the broadcast key, and on an
// insert or delete either keeps its entry, takes the new entry, or takes the
// entry of its left or right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
  parameter int PRIORITY_BITS = 8
) (
  input  wire                           clk,
  input  wire spq_pkg::cmd_t            cmd,
  input  wire [spq_pkg::DATA_W-1:0]     new_data,
  input  wire [PRIORITY_BITS-1:0]       key,
  input  wire                           occ,
  input  wire                           left_le,
  input  wire                           left_eq,
  input  wire [spq_pkg::DATA_W-1:0]     left_data,
  input  wire [PRIORITY_BITS-1:0]       left_prio,
  input  wire [spq_pkg::DATA_W-1:0]     right_data,
  input  wire [PRIORITY_BITS-1:0]       right_prio,
  output logic [spq_pkg::DATA_W-1:0]    data,
  output logic [PRIORITY_BITS-1:0]      prio,
  output spq_pkg::flags_t               flags
);

  import spq_pkg::*;

  // Compare the held entry against the key
  always_comb begin
    flags.le  = occ && (prio <= key);
    flags.lt  = occ && (prio <  key);
    flags.eq  = occ && (prio == key);
    flags.hit = flags.eq && !left_eq;
  end

  // Update the slot: keep, take new entry, shift right on insert, shift left on delete
  always_ff @(posedge clk) begin
    if (cmd.ins && !flags.le) begin
      if (left_le) begin
        data <= new_data;
        prio <= key;
      end else begin
        data <= left_data;
        prio <= left_prio;
      end
    end else if (cmd.del && !flags.lt) begin
      data <= right_data;
      prio <= right_prio;
    end
  end

endmodule

`default_nettype wire

### src/sorted_priority_queue.sv
// The queue takes one item per clock cycle and returns one result item for
// each; the result sits in an output register, so a new item is accepted
// whenever that register is empty or is being taken in the same cycle. The
// entries live in a row of CAPACITY cells that all compare the key at once;
// the path that sets the clock is that compare followed by the OR over all
// cells that finds the key and picks the removed data. Storage starts
// empty after reset with no clearing pass.
// ----------------------------------------------------------------------------
// sorted_priority_queue: sorted-list priority queue built from a cell chain
// Inserts keep ascending priority with FIFO order among equal priorities;
// deletes remove the first entry whose priority equals the key.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 8,
  localparam int CNT_W        = $clog2(CAPACITY + 1)
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 mode,
  input  wire signed [spq_pkg::DATA_W-1:0]    item_data,
  input  wire [PRIORITY_BITS-1:0]             item_priority,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output spq_pkg::status_t                    status,
  output logic signed [spq_pkg::DATA_W-1:0]   removed_data,
  output logic [CNT_W-1:0]                    entry_count
);

  import spq_pkg::*;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                accept;
  logic                full;
  logic                found;
  cmd_t                cmd;
  status_t             status_next;
  logic [DATA_W-1:0]   removed_next;

  logic [DATA_W-1:0]        cell_data  [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];
  flags_t                   cell_flags [CAPACITY];
  logic [CAPACITY-1:0]      occ;

  // Accept when the result register is free or emptying
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CNT_W'(CAPACITY));

  // Build the cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     l_le;
    logic                     l_eq;
    logic [DATA_W-1:0]        l_data;
    logic [PRIORITY_BITS-1:0] l_prio;
    logic [DATA_W-1:0]        r_data;
    logic [PRIORITY_BITS-1:0] r_prio;

    assign occ[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign l_le   = 1'b1;
      assign l_eq   = 1'b0;
      assign l_data = item_data;
      assign l_prio = item_priority;
    end else begin : g_body
      assign l_le   = cell_flags[i-1].le;
      assign l_eq   = cell_flags[i-1].eq;
      assign l_data = cell_data[i-1];
      assign l_prio = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_data = cell_data[i];
      assign r_prio = cell_prio[i];
    end else begin : g_inner
      assign r_data = cell_data[i+1];
      assign r_prio = cell_prio[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_data  (item_data),
      .key       (item_priority),
      .occ       (occ[i]),
      .left_le   (l_le),
      .left_eq   (l_eq),
      .left_data (l_data),
      .left_prio (l_prio),
      .right_data(r_data),
      .right_prio(r_prio),
      .data      (cell_data[i]),
      .prio      (cell_prio[i]),
      .flags     (cell_flags[i])
    );
  end

  // Gather the key match and the data of the first matching cell
  always_comb begin
    found        = 1'b0;
    removed_next = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found        = found | cell_flags[i].eq;
      removed_next = removed_next | ({DATA_W{cell_flags[i].hit}} & cell_data[i]);
    end
  end

  // Decide the operation and its result
  always_comb begin
    cmd.ins     = 1'b0;
    cmd.del     = 1'b0;
    count_next  = count;
    status_next = ST_INSERTED;
    if (mode == MODE_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        cmd.ins     = accept;
        count_next  = count + CNT_W'(1);
        status_next = ST_INSERTED;
      end
    end else begin
      if (found) begin
        cmd.del     = accept;
        count_next  = count - CNT_W'(1);
        status_next = ST_DELETED;
      end else begin
        status_next = ST_MISSING;
      end
    end
  end

  // Hold the fill count and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      removed_data <= (status_next == ST_DELETED) ? removed_next : '0;
      entry_count  <= count_next;
    end
  end

endmodule

`default_nettype wire

### src/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the result channel for stable stalled items and for results that
// are consistent with the queue's capacity and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 8,
  localparam int CNT_W        = $clog2(CAPACITY + 1)
) (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_stall,
  input wire                          mode,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire spq_pkg::status_t        status,
  input wire [spq_pkg::DATA_W-1:0]    removed_data,
  input wire [CNT_W-1:0]              entry_count
);

  import spq_pkg::*;

  // Hold a stalled result item unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(removed_data) && $stable(entry_count))
    else $error("stalled result item changed");

  // Drop removed data on anything but a delete
  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DELETED) |-> (removed_data == '0))
    else $error("removed data not zero outside a delete");

  // Never report more entries than the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= CNT_W'(CAPACITY)))
    else $error("entry count above capacity");

  // Refuse an insert only when the queue is full
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (entry_count == CNT_W'(CAPACITY)))
    else $error("full status with free slots");

  // An accepted insert reports inserted or full, a delete reports deleted or missing
  a_status_mode: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid &&
      (($past(mode) == MODE_INSERT) ? (status == ST_INSERTED || status == ST_FULL)
                                    : (status == ST_DELETED || status == ST_MISSING)))
    else $error("status does not match the operation");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY     (CAPACITY),
  .PRIORITY_BITS(PRIORITY_BITS)
) u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .mode         (mode),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .removed_data (removed_data),
  .entry_count  (entry_count)
);

`default_nettype wire

### sim/sorted_priority_queue_test.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: self-checking bench for the sorted priority queue
// Drives insert and delete items through the valid/stall input channel and
// keeps its own sorted copy of the queue to work out each result item. Every
// result item taken from the output channel is compared field by field with
// the oldest expected one. Both channels idle in random bursts.
// ----------------------------------------------------------------------------

module sorted_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int CAP          = 16;
  localparam int PRIO_W       = 8;
  localparam int CNT_W        = $clog2(CAP + 1);
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 5;
  localparam int HANG_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_PRINTED  = 50;

  typedef struct {
    status_t                   status;
    logic signed [DATA_W-1:0]  removed;
    logic [CNT_W-1:0]          count;
  } queue_result_t;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic                        mode;
  logic signed [DATA_W-1:0]    item_data;
  logic [PRIO_W-1:0]           item_priority;
  logic                        out_valid;
  logic                        out_stall;
  status_t                     status;
  logic signed [DATA_W-1:0]    removed_data;
  logic [CNT_W-1:0]            entry_count;

  // Shadow copy of the queue contents, head at index 0
  logic signed [DATA_W-1:0]    held_data [CAP];
  logic [PRIO_W-1:0]           held_prio [CAP];
  int                          held_count;

  queue_result_t               pending_results[$];
  queue_result_t               oldest;
  int                          error_count;
  int                          quiet_cycles = 0;
  bit                          idle_en;

  sorted_priority_queue #(
    .CAPACITY      (CAP),
    .PRIORITY_BITS (PRIO_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .item_data     (item_data),
    .item_priority (item_priority),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_data  (removed_data),
    .entry_count   (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Print one mismatch line and count it
  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("ERROR %0t ns: %s", $time, msg);
    end
    error_count++;
  endtask

  // Apply one operation to the shadow queue and return the result it gives
  function automatic queue_result_t apply_queue_op(input logic op,
                                                   input logic signed [DATA_W-1:0] data,
                                                   input logic [PRIO_W-1:0] key);
    queue_result_t r;
    int pos;
    int i;
    r.removed = '0;
    pos = 0;
    if (op == MODE_INSERT) begin
      if (held_count >= CAP) begin
        r.status = ST_FULL;
      end else begin
        // go behind every entry with priority <= key, head ties included
        while (pos < held_count && held_prio[pos] <= key) pos++;
        for (i = held_count; i > pos; i--) begin
          held_data[i] = held_data[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_data[pos] = data;
        held_prio[pos] = key;
        held_count++;
        r.status = ST_INSERTED;
      end
    end else begin
      while (pos < held_count && held_prio[pos] != key) pos++;
      if (pos >= held_count) begin
        r.status = ST_MISSING;
      end else begin
        r.removed = held_data[pos];
        for (i = pos; i + 1 < held_count; i++) begin
          held_data[i] = held_data[i+1];
          held_prio[i] = held_prio[i+1];
        end
        held_count--;
        r.status = ST_DELETED;
      end
    end
    r.count = held_count[CNT_W-1:0];
    return r;
  endfunction

  // Send one item, wait for it to be taken, then predict its result
  task automatic send_item(input logic op, input logic signed [DATA_W-1:0] data,
                           input logic [PRIO_W-1:0] key);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= op;
    item_data     <= data;
    item_priority <= key;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_queue_op(op, data, key));
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_for_empty_pipe();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Pick a priority: mostly a narrow band so ties and hits are common
  function automatic logic [PRIO_W-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return PRIO_W'($urandom_range(0, 7));
    if (r < 8) return PRIO_W'($urandom_range(0, (1 << PRIO_W) - 1));
    if (r == 8) return '0;
    return '1;
  endfunction

  // Random mix with a given share of inserts; deletes mostly hit a held key
  task automatic run_random_items(input int n_items, input int insert_pct);
    logic [PRIO_W-1:0] key;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < insert_pct) begin
        send_item(MODE_INSERT, DATA_W'($urandom), pick_priority());
      end else begin
        if (held_count > 0 && $urandom_range(0, 3) != 0) begin
          key = held_prio[$urandom_range(0, held_count - 1)];
        end else begin
          key = pick_priority();
        end
        send_item(MODE_DELETE, DATA_W'($urandom), key);
      end
    end
  endtask

  // Delete from an empty queue reports a missing key
  task automatic test_empty_delete();
    send_item(MODE_DELETE, 32'h5a5a_a5a5, 8'd0);
  endtask

  // Extreme data and priorities, plus a tie with the head entry
  task automatic test_extremes();
    send_item(MODE_INSERT, 32'sh7fff_ffff, 8'hff);
    send_item(MODE_INSERT, 32'sh8000_0000, 8'h00);
    send_item(MODE_INSERT, -32'sd1, 8'h00);
    send_item(MODE_DELETE, 32'h1234_5678, 8'h00);
    send_item(MODE_DELETE, 32'hffff_ffff, 8'h00);
    send_item(MODE_DELETE, 32'h0000_0000, 8'hff);
    send_item(MODE_DELETE, 32'h0000_0000, 8'hff);
  endtask

  // Fill to capacity with ties, then one refused insert
  task automatic test_fill_to_full();
    repeat (CAP) begin
      send_item(MODE_INSERT, DATA_W'($urandom), PRIO_W'($urandom_range(0, 5)));
    end
    send_item(MODE_INSERT, 32'sh0bad_f00d, 8'd3);
  endtask

  // Segments that swing between near full and near empty, idling on and off
  task automatic test_random_traffic();
    int seg;
    for (seg = 0; seg < 20; seg++) begin
      idle_en = ($urandom_range(0, 3) != 0);
      case (seg % 3)
        0: run_random_items(60, 75);
        1: run_random_items(60, 30);
        default: run_random_items(60, 50);
      endcase
      if (seg == 5 || seg == 12) begin
        wait_for_empty_pipe();
      end
    end
  endtask

  // Back-to-back items with both sides always ready
  task automatic test_no_idle();
    idle_en = 1'b0;
    run_random_items(150, 70);
    run_random_items(150, 40);
  endtask

  // Stall the result channel in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Compare each taken result with the oldest expected one
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error("result item with no item pending");
      end else begin
        oldest = pending_results.pop_front();
        if (status !== oldest.status)
          report_error($sformatf("status %0d, expected %0d", status, oldest.status));
        if (removed_data !== oldest.removed)
          report_error($sformatf("removed_data %0d, expected %0d",
                                 removed_data, oldest.removed));
        if (entry_count !== oldest.count)
          report_error($sformatf("entry_count %0d, expected %0d",
                                 entry_count, oldest.count));
      end
    end
  end

  // End the run when no item moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("sorted_priority_queue test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    error_count   = 0;
    held_count    = 0;
    idle_en       = 1'b1;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    mode          <= MODE_INSERT;
    item_data     <= '0;
    item_priority <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_empty_delete();
    test_extremes();
    test_fill_to_full();
    test_random_traffic();
    test_no_idle();

    // Drain the remaining results, then settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_error("expected results left over");
    end
    if (error_count == 0) begin
      $display("sorted_priority_queue test passed");
    end else begin
      $display("sorted_priority_queue test failed");
    end
    $finish;
  end

endmodule
